@@ hw/rtl/lpu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and helpers for the lens point undistortion unit.
// No dependencies; used by every other file of the block.
package lpu_pkg;

   localparam int ITERATIONS = 5;

   localparam int PIX_W      = 20;
   localparam int COORD_W    = 24;
   localparam int DIFF_W     = PIX_W + 1;
   localparam int QUO_W      = 25;
   localparam int NUM_W      = 56;
   localparam int DEN_W      = 44;
   localparam int DIV_LAT    = QUO_W + 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int FIFO_CW    = 3;

   localparam logic signed [COORD_W-1:0] Q_MAX   = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN   = 24'sh800000;
   localparam logic signed [DEN_W-1:0]   ONE_Q20 = 44'sd1048576;

   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_RADIAL_K1 = 3'd4;
   localparam logic [2:0] REG_RADIAL_K2 = 3'd5;
   localparam logic [2:0] REG_TANGENT_P1 = 3'd6;
   localparam logic [2:0] REG_TANGENT_P2 = 3'd7;

   typedef struct packed {
      logic [PIX_W-1:0]          focal_x;
      logic [PIX_W-1:0]          focal_y;
      logic [PIX_W-1:0]          center_x;
      logic [PIX_W-1:0]          center_y;
      logic signed [COORD_W-1:0] k1;
      logic signed [COORD_W-1:0] k2;
      logic signed [COORD_W-1:0] p1;
      logic signed [COORD_W-1:0] p2;
   } lpu_cfg_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } lpu_diff_type;

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic                      flag;
   } lpu_item_type;

   // round to nearest at bit 20, ties away from zero
   function automatic logic signed [63:0] rnd20(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] q;
      mag = v[63] ? -v : v;
      q = (mag + 64'd524288) >> 20;
      return v[63] ? -$signed(q) : $signed(q);
   endfunction

endpackage

@@ hw/rtl/lens_point_undistortion_unit.sv @@
`timescale 1ns / 1ps
// Lens point undistortion unit: pixel coordinate in, undistorted normalized Q4.20 out.
// Depends on lpu_pkg, lpu_front, lpu_back.
//
// Usage:
//   Request channel (req_valid/req_stall) carries one distorted pixel pair per beat,
//   unsigned Q12.8. Response channel (rsp_valid/rsp_stall) returns norm_x, norm_y in
//   signed Q4.20 plus a saturated flag, one response beat per request beat, in order.
//   Intrinsics and distortion coefficients are written over the csr_ APB port while
//   the unit is idle; pready is tied high, reads return the register contents.
// Throughput: one beat per clock when the response side does not stall.
// Pipeline: the queue entry, the pipelined normalization divider (one quotient bit
//   per stage), then 5 iterations (each 7 arithmetic stages plus a 27 stage divider),
//   and the response register.
// A 4-beat queue sits between the front end and the pipeline; when the response
//   register is held by rsp_stall the whole pipeline freezes, and req_stall rises
//   once the queue fills.
// Reset (synchronous, active high) empties the queue and pipeline and loads
//   focal lengths of 1.0 with all other registers zero.
module lens_point_undistortion_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [19:0]  req_pixel_x,
   input  logic [19:0]  req_pixel_y,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic signed [23:0] rsp_norm_x,
   output logic signed [23:0] rsp_norm_y,
   output logic         rsp_saturated,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [19:0]        focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic signed [23:0] radial_k1_ff, radial_k2_ff, tangent_p1_ff, tangent_p2_ff;
   logic [2:0]         reg_idx;
   logic               csr_write;

   lpu_pkg::lpu_cfg_type  cfg;
   lpu_pkg::lpu_diff_type diff_head;
   lpu_pkg::lpu_item_type back_out;
   logic                  back_enable;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_sat_ff;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff    <= 20'd256;
         focal_y_ff    <= 20'd256;
         center_x_ff   <= '0;
         center_y_ff   <= '0;
         radial_k1_ff  <= '0;
         radial_k2_ff  <= '0;
         tangent_p1_ff <= '0;
         tangent_p2_ff <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            lpu_pkg::REG_FOCAL_X:    focal_x_ff    <= csr_pwdata[19:0];
            lpu_pkg::REG_FOCAL_Y:    focal_y_ff    <= csr_pwdata[19:0];
            lpu_pkg::REG_CENTER_X:   center_x_ff   <= csr_pwdata[19:0];
            lpu_pkg::REG_CENTER_Y:   center_y_ff   <= csr_pwdata[19:0];
            lpu_pkg::REG_RADIAL_K1:  radial_k1_ff  <= $signed(csr_pwdata[23:0]);
            lpu_pkg::REG_RADIAL_K2:  radial_k2_ff  <= $signed(csr_pwdata[23:0]);
            lpu_pkg::REG_TANGENT_P1: tangent_p1_ff <= $signed(csr_pwdata[23:0]);
            lpu_pkg::REG_TANGENT_P2: tangent_p2_ff <= $signed(csr_pwdata[23:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lpu_pkg::REG_FOCAL_X:    csr_prdata = 32'(focal_x_ff);
         lpu_pkg::REG_FOCAL_Y:    csr_prdata = 32'(focal_y_ff);
         lpu_pkg::REG_CENTER_X:   csr_prdata = 32'(center_x_ff);
         lpu_pkg::REG_CENTER_Y:   csr_prdata = 32'(center_y_ff);
         lpu_pkg::REG_RADIAL_K1:  csr_prdata = 32'(radial_k1_ff);
         lpu_pkg::REG_RADIAL_K2:  csr_prdata = 32'(radial_k2_ff);
         lpu_pkg::REG_TANGENT_P1: csr_prdata = 32'(tangent_p1_ff);
         lpu_pkg::REG_TANGENT_P2: csr_prdata = 32'(tangent_p2_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.focal_x  = focal_x_ff;
      cfg.focal_y  = focal_y_ff;
      cfg.center_x = center_x_ff;
      cfg.center_y = center_y_ff;
      cfg.k1       = radial_k1_ff;
      cfg.k2       = radial_k2_ff;
      cfg.p1       = tangent_p1_ff;
      cfg.p2       = tangent_p2_ff;
   end

   // pipeline advances unless a finished beat is held at the output
   assign back_enable = !rsp_valid_ff || !rsp_stall;

   lpu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .pop         (back_enable),
      .head        (diff_head)
   );

   lpu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .enable   (back_enable),
      .cfg      (cfg),
      .diff     (diff_head),
      .item_out (back_out)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (back_enable) rsp_valid_ff <= back_out.valid;
   end

   always_ff @(posedge clock) begin
      if (back_enable) begin
         rsp_x_ff   <= back_out.x;
         rsp_y_ff   <= back_out.y;
         rsp_sat_ff <= back_out.flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_norm_x    = rsp_x_ff;
   assign rsp_norm_y    = rsp_y_ff;
   assign rsp_saturated = rsp_sat_ff;

`ifndef NO_ASSERTIONS
   a_full_queue_has_head : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> diff_head.valid)
      else $error("queue reports full with no head entry");

   a_reset_clears_output : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_frozen_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && diff_head.valid |=> diff_head.valid)
      else $error("queue drained while pipeline frozen");
`endif

endmodule

@@ hw/rtl/lpu_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated to Q4.20.
// Depends on lpu_pkg.
module lpu_div (
   input  logic                                clock,
   input  logic                                enable,
   input  logic                                neg_in,
   input  logic [lpu_pkg::NUM_W-1:0]           num_in,
   input  logic [lpu_pkg::DEN_W-1:0]           den_in,
   output logic signed [lpu_pkg::COORD_W-1:0]  quo_out,
   output logic                                sat_out
);

   localparam int QW = lpu_pkg::QUO_W;
   localparam int DW = lpu_pkg::DEN_W;

   logic [DW-1:0] rem_ff [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [DW-1:0] den_ff [0:QW];
   logic [QW:0]   neg_ff;
   logic [QW:0]   nz_ff;
   logic [QW:0]   dz_ff;
   logic [QW:0]   ovf_ff;

   logic signed [lpu_pkg::COORD_W-1:0] quo_in;
   logic                               sat_in;
   logic signed [lpu_pkg::COORD_W-1:0] quo_ff_o;
   logic                               sat_ff_o;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= DW'(num_in[lpu_pkg::NUM_W-1:QW]);
         low_ff[0] <= num_in[QW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         neg_ff[0] <= neg_in;
         nz_ff[0]  <= (num_in != '0);
         dz_ff[0]  <= (den_in == '0);
         ovf_ff[0] <= (DW'(num_in[lpu_pkg::NUM_W-1:QW]) >= den_in);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[k], low_ff[k][QW-1]};
      assign ge    = (trial >= {1'b0, den_ff[k]});
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= ge ? DW'(trial - {1'b0, den_ff[k]}) : DW'(trial);
            low_ff[k+1] <= low_ff[k] << 1;
            quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            nz_ff[k+1]  <= nz_ff[k];
            dz_ff[k+1]  <= dz_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   logic       round_up;
   logic [QW:0] q_rnd;

   always_comb begin
      round_up = ({rem_ff[QW], 1'b0} >= {1'b0, den_ff[QW]});
      q_rnd    = {1'b0, quo_ff[QW]} + (QW+1)'(round_up);
      sat_in   = 1'b0;
      quo_in   = '0;
      if (dz_ff[QW]) begin
         sat_in = 1'b1;
         if (nz_ff[QW]) quo_in = neg_ff[QW] ? lpu_pkg::Q_MIN : lpu_pkg::Q_MAX;
      end else if (ovf_ff[QW]) begin
         sat_in = 1'b1;
         quo_in = neg_ff[QW] ? lpu_pkg::Q_MIN : lpu_pkg::Q_MAX;
      end else if (neg_ff[QW]) begin
         if (q_rnd > (QW+1)'(8388608)) begin
            sat_in = 1'b1;
            quo_in = lpu_pkg::Q_MIN;
         end else begin
            quo_in = -$signed(lpu_pkg::COORD_W'(q_rnd));
         end
      end else begin
         if (q_rnd > (QW+1)'(8388607)) begin
            sat_in = 1'b1;
            quo_in = lpu_pkg::Q_MAX;
         end else begin
            quo_in = $signed(lpu_pkg::COORD_W'(q_rnd));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff_o <= quo_in;
         sat_ff_o <= sat_in;
      end
   end

   assign quo_out = quo_ff_o;
   assign sat_out = sat_ff_o;

endmodule

@@ hw/rtl/lpu_iter.sv @@
`timescale 1ns / 1ps
// One undistortion iteration: radial/tangential terms, denominator, two divides.
// Depends on lpu_pkg and lpu_div.
module lpu_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  lpu_pkg::lpu_cfg_type  cfg,
   input  lpu_pkg::lpu_item_type item_in,
   output lpu_pkg::lpu_item_type item_out
);

   localparam int PRE  = 7;
   localparam int SIDE = PRE + lpu_pkg::DIV_LAT;

   typedef struct packed {
      logic                               valid;
      logic signed [lpu_pkg::COORD_W-1:0] x0;
      logic signed [lpu_pkg::COORD_W-1:0] y0;
      logic                               flag;
   } side_type;

   side_type side_ff [1:SIDE];

   logic signed [23:0] xi, yi, k1, k2, p1, p2;
   assign xi = item_in.x;
   assign yi = item_in.y;
   assign k1 = cfg.k1;
   assign k2 = cfg.k2;
   assign p1 = cfg.p1;
   assign p2 = cfg.p2;

   logic signed [47:0] x2p_ff, y2p_ff, xyp_ff;
   logic signed [27:0] x2_ff, y2_ff, xy2_ff, xy3_ff;
   logic signed [28:0] r2_3_ff, r2_4_ff, r2_5_ff;
   logic signed [29:0] ax_ff, by_ff;
   logic signed [52:0] mk2_ff;
   logic signed [51:0] m1_ff, m4_ff;
   logic signed [53:0] m2_ff, m3_ff;
   logic signed [32:0] inner_ff;
   logic signed [33:0] ddx_ff, ddy_ff;
   logic signed [61:0] prod_ff;
   logic signed [34:0] numx6_ff, numy6_ff, numx7_ff, numy7_ff;
   logic signed [lpu_pkg::DEN_W-1:0] den7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= SIDE; k++) side_ff[k].valid <= 1'b0;
      end else if (enable) begin
         side_ff[1] <= '{valid: item_in.valid, x0: item_in.x0, y0: item_in.y0,
                         flag: item_in.flag};
         for (int k = 2; k <= SIDE; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x2p_ff   <= xi * xi;
         y2p_ff   <= yi * yi;
         xyp_ff   <= xi * yi;
         x2_ff    <= 28'(lpu_pkg::rnd20(64'(x2p_ff)));
         y2_ff    <= 28'(lpu_pkg::rnd20(64'(y2p_ff)));
         xy2_ff   <= 28'(lpu_pkg::rnd20(64'(xyp_ff)));
         r2_3_ff  <= 29'(x2_ff) + 29'(y2_ff);
         ax_ff    <= 30'(x2_ff) + 30'(y2_ff) + (30'(x2_ff) <<< 1);
         by_ff    <= 30'(x2_ff) + 30'(y2_ff) + (30'(y2_ff) <<< 1);
         xy3_ff   <= xy2_ff;
         mk2_ff   <= k2 * r2_3_ff;
         m1_ff    <= p1 * xy3_ff;
         m2_ff    <= p2 * ax_ff;
         m3_ff    <= p1 * by_ff;
         m4_ff    <= p2 * xy3_ff;
         r2_4_ff  <= r2_3_ff;
         inner_ff <= 33'(lpu_pkg::rnd20(64'(mk2_ff))) + 33'(k1);
         ddx_ff   <= 34'(lpu_pkg::rnd20((64'(m1_ff) <<< 1) + 64'(m2_ff)));
         ddy_ff   <= 34'(lpu_pkg::rnd20(64'(m3_ff) + (64'(m4_ff) <<< 1)));
         r2_5_ff  <= r2_4_ff;
         prod_ff  <= inner_ff * r2_5_ff;
         numx6_ff <= 35'(side_ff[5].x0) - 35'(ddx_ff);
         numy6_ff <= 35'(side_ff[5].y0) - 35'(ddy_ff);
         den7_ff  <= lpu_pkg::DEN_W'(lpu_pkg::rnd20(64'(prod_ff))) + lpu_pkg::ONE_Q20;
         numx7_ff <= numx6_ff;
         numy7_ff <= numy6_ff;
      end
   end

   logic [34:0]               magx, magy;
   logic [lpu_pkg::DEN_W-1:0] magd;
   logic signed [23:0]        qx, qy;
   logic                      sx, sy;

   assign magx = numx7_ff[34] ? 35'(-numx7_ff) : 35'(numx7_ff);
   assign magy = numy7_ff[34] ? 35'(-numy7_ff) : 35'(numy7_ff);
   assign magd = den7_ff[lpu_pkg::DEN_W-1] ? lpu_pkg::DEN_W'(-den7_ff)
                                           : lpu_pkg::DEN_W'(den7_ff);

   lpu_div u_div_x (
      .clock   (clock),
      .enable  (enable),
      .neg_in  (numx7_ff[34] ^ den7_ff[lpu_pkg::DEN_W-1]),
      .num_in  (lpu_pkg::NUM_W'(magx) << 20),
      .den_in  (magd),
      .quo_out (qx),
      .sat_out (sx)
   );

   lpu_div u_div_y (
      .clock   (clock),
      .enable  (enable),
      .neg_in  (numy7_ff[34] ^ den7_ff[lpu_pkg::DEN_W-1]),
      .num_in  (lpu_pkg::NUM_W'(magy) << 20),
      .den_in  (magd),
      .quo_out (qy),
      .sat_out (sy)
   );

   assign item_out = '{valid: side_ff[SIDE].valid, x: qx, y: qy, x0: side_ff[SIDE].x0,
                       y0: side_ff[SIDE].y0, flag: side_ff[SIDE].flag | sx | sy};

endmodule

@@ hw/rtl/lpu_front.sv @@
`timescale 1ns / 1ps
// Front end: takes request beats, removes the principal point, queues the offsets.
// Depends on lpu_pkg.
module lpu_front (
   input  logic                         clock,
   input  logic                         reset,
   input  lpu_pkg::lpu_cfg_type         cfg,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lpu_pkg::PIX_W-1:0]    req_pixel_x,
   input  logic [lpu_pkg::PIX_W-1:0]    req_pixel_y,
   input  logic                         pop,
   output lpu_pkg::lpu_diff_type        head
);

   localparam int DW = lpu_pkg::DIFF_W;

   logic [2*DW-1:0]                fifo_mem [0:lpu_pkg::FIFO_DEPTH-1];
   logic [lpu_pkg::FIFO_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [lpu_pkg::FIFO_CW-1:0]    count_ff;
   logic                           push, take;
   logic signed [DW-1:0]           dx, dy;

   assign dx = $signed({1'b0, req_pixel_x}) - $signed({1'b0, cfg.center_x});
   assign dy = $signed({1'b0, req_pixel_y}) - $signed({1'b0, cfg.center_y});

   assign req_stall = (count_ff == lpu_pkg::FIFO_CW'(lpu_pkg::FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) fifo_mem[wr_ptr_ff] <= {dx, dy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (take) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + lpu_pkg::FIFO_CW'(push) - lpu_pkg::FIFO_CW'(take);
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.dx    = $signed(fifo_mem[rd_ptr_ff][2*DW-1:DW]);
   assign head.dy    = $signed(fifo_mem[rd_ptr_ff][DW-1:0]);

endmodule

@@ hw/rtl/lpu_back.sv @@
`timescale 1ns / 1ps
// Back end: normalization divides followed by the chain of undistortion iterations.
// Depends on lpu_pkg, lpu_div and lpu_iter.
module lpu_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  lpu_pkg::lpu_cfg_type  cfg,
   input  lpu_pkg::lpu_diff_type diff,
   output lpu_pkg::lpu_item_type item_out
);

   localparam int DL = lpu_pkg::DIV_LAT;

   logic [DL-1:0]                 vld_ff;
   logic [lpu_pkg::DIFF_W-1:0]    magx, magy;
   logic signed [23:0]            qx, qy;
   logic                          sx, sy;
   lpu_pkg::lpu_item_type         chain [0:lpu_pkg::ITERATIONS];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (enable) vld_ff <= {vld_ff[DL-2:0], diff.valid};
   end

   assign magx = diff.dx[lpu_pkg::DIFF_W-1] ? lpu_pkg::DIFF_W'(-diff.dx)
                                             : lpu_pkg::DIFF_W'(diff.dx);
   assign magy = diff.dy[lpu_pkg::DIFF_W-1] ? lpu_pkg::DIFF_W'(-diff.dy)
                                             : lpu_pkg::DIFF_W'(diff.dy);

   lpu_div u_norm_x (
      .clock   (clock),
      .enable  (enable),
      .neg_in  (diff.dx[lpu_pkg::DIFF_W-1]),
      .num_in  (lpu_pkg::NUM_W'(magx) << 20),
      .den_in  (lpu_pkg::DEN_W'(cfg.focal_x)),
      .quo_out (qx),
      .sat_out (sx)
   );

   lpu_div u_norm_y (
      .clock   (clock),
      .enable  (enable),
      .neg_in  (diff.dy[lpu_pkg::DIFF_W-1]),
      .num_in  (lpu_pkg::NUM_W'(magy) << 20),
      .den_in  (lpu_pkg::DEN_W'(cfg.focal_y)),
      .quo_out (qy),
      .sat_out (sy)
   );

   assign chain[0] = '{valid: vld_ff[DL-1], x: qx, y: qy, x0: qx, y0: qy, flag: sx | sy};

   for (genvar i = 0; i < lpu_pkg::ITERATIONS; i++) begin : g_iter
      lpu_iter u_iter (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .cfg      (cfg),
         .item_in  (chain[i]),
         .item_out (chain[i+1])
      );
   end

   assign item_out = chain[lpu_pkg::ITERATIONS];

endmodule

@@ sim/lens_point_undistortion_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for lens_point_undistortion_unit: pixel beats with random
// bursts, random response stalls, CSR phases over APB; results predicted in SV.
// Depends on lpu_pkg and the unit RTL.
module lens_point_undistortion_unit_test;

   typedef struct packed {
      logic [19:0] px;
      logic [19:0] py;
   } pixel_beat_type;

   typedef struct packed {
      logic signed [23:0] nx;
      logic signed [23:0] ny;
      logic               sat;
   } norm_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [19:0] req_pixel_x = '0;
   logic [19:0] req_pixel_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_norm_x, rsp_norm_y;
   logic rsp_saturated;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lens_point_undistortion_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the registers
   longint unsigned fx = 256, fy = 256, cx = 0, cy = 0;
   longint k1 = 0, k2 = 0, p1 = 0, p2 = 0;

   pixel_beat_type pixel_queue[$];
   norm_beat_type  norm_queue[$];
   int errors = 0;
   bit hold_sender = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;

   function automatic longint round20(longint v);
      longint unsigned m, q;
      m = (v < 0) ? -v : v;
      q = (m + (64'd1 << 19)) >> 20;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sat_divide(longint num, longint den, ref bit flag);
      longint unsigned mn, md, q;
      longint r;
      if (den == 0) begin
         flag = 1'b1;
         return (num > 0) ? 8388607 : (num < 0) ? -8388608 : 0;
      end
      mn = (num < 0) ? -num : num;
      md = (den < 0) ? -den : den;
      q = (2 * mn + md) / (2 * md);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      r = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
      if (r > 8388607) begin flag = 1'b1; return 8388607; end
      if (r < -8388608) begin flag = 1'b1; return -8388608; end
      return r;
   endfunction

   function automatic norm_beat_type undistort(pixel_beat_type b);
      bit flag;
      longint x0, y0, x, y, x2, y2, xy, r2, inner, den, ddx, ddy, nx;
      norm_beat_type o;
      flag = 1'b0;
      x0 = sat_divide((longint'(b.px) - longint'(cx)) * (64'sd1 << 20), fx, flag);
      y0 = sat_divide((longint'(b.py) - longint'(cy)) * (64'sd1 << 20), fy, flag);
      x = x0;
      y = y0;
      for (int i = 0; i < lpu_pkg::ITERATIONS; i++) begin
         x2 = round20(x * x);
         y2 = round20(y * y);
         xy = round20(x * y);
         r2 = x2 + y2;
         inner = round20(k2 * r2) + k1;
         den = (64'sd1 << 20) + round20(inner * r2);
         ddx = round20(2 * p1 * xy + p2 * (r2 + 2 * x2));
         ddy = round20(p1 * (r2 + 2 * y2) + 2 * p2 * xy);
         nx = sat_divide((x0 - ddx) * (64'sd1 << 20), den, flag);
         y = sat_divide((y0 - ddy) * (64'sd1 << 20), den, flag);
         x = nx;
      end
      o.nx = x[23:0];
      o.ny = y[23:0];
      o.sat = flag;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            norm_queue.push_back(undistort({req_pixel_x, req_pixel_y}));
            void'(pixel_queue.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (pixel_queue.size() != 0 && !hold_sender && gap_left == 0) begin
               req_valid <= 1'b1;
               req_pixel_x <= pixel_queue[0].px;
               req_pixel_y <= pixel_queue[0].py;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
               end
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // response stall pattern and checker
   always @(posedge clock) begin
      norm_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (norm_queue.size() == 0) begin
               $display("%0t: unexpected beat got %h %h %b", $time, rsp_norm_x,
                        rsp_norm_y, rsp_saturated);
               errors++;
            end else begin
               want = norm_queue.pop_front();
               if (want.nx !== rsp_norm_x || want.ny !== rsp_norm_y
                   || want.sat !== rsp_saturated) begin
                  $display("%0t: mismatch exp %h %h %b got %h %h %b", $time, want.nx,
                           want.ny, want.sat, rsp_norm_x, rsp_norm_y, rsp_saturated);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 499) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic tick();
      @(posedge clock);
   endtask

   task automatic drain();
      while (pixel_queue.size() != 0 || req_valid || norm_queue.size() != 0) tick();
      repeat (300) tick();
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      tick();
      csr_penable <= 1'b1;
      tick();
      while (!csr_pready) tick();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         lpu_pkg::REG_FOCAL_X: fx = value[19:0];
         lpu_pkg::REG_FOCAL_Y: fy = value[19:0];
         lpu_pkg::REG_CENTER_X: cx = value[19:0];
         lpu_pkg::REG_CENTER_Y: cy = value[19:0];
         lpu_pkg::REG_RADIAL_K1: k1 = longint'(signed'(value[23:0]));
         lpu_pkg::REG_RADIAL_K2: k2 = longint'(signed'(value[23:0]));
         lpu_pkg::REG_TANGENT_P1: p1 = longint'(signed'(value[23:0]));
         lpu_pkg::REG_TANGENT_P2: p2 = longint'(signed'(value[23:0]));
         default: ;
      endcase
      tick();
   endtask

   task automatic send(logic [19:0] px, logic [19:0] py);
      pixel_beat_type b;
      b.px = px;
      b.py = py;
      pixel_queue.push_back(b);
   endtask

   function automatic logic [19:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 20'h0;
         1: return 20'hFFFFF;
         2: return 20'($urandom_range(0, 4095));
         default: return 20'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] rand_coef(int scale);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 32'h7FFFFF;
      if (sel == 1) return 32'h800000;
      if (sel == 2) return 32'h0;
      if (sel < 5) return $urandom();
      return $urandom_range(0, 2 * scale) - scale;
   endfunction

   initial begin
      repeat (4) tick();
      reset <= 1'b0;
      tick();
      // directed: extremes at reset settings
      send(0, 0);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'hFFFFF, 0);
      send(0, 20'hFFFFF);
      send(256, 512);
      send(20'h00800, 20'h00400);
      drain();
      // barrel distortion with center and tangential terms
      csr_write(lpu_pkg::REG_FOCAL_X, 20'd204800);
      csr_write(lpu_pkg::REG_FOCAL_Y, 20'd153600);
      csr_write(lpu_pkg::REG_CENTER_X, 20'd163840);
      csr_write(lpu_pkg::REG_CENTER_Y, 20'd122880);
      csr_write(lpu_pkg::REG_RADIAL_K1, -24'sd200000);
      csr_write(lpu_pkg::REG_RADIAL_K2, 24'sd50000);
      csr_write(lpu_pkg::REG_TANGENT_P1, 24'sd1000);
      csr_write(lpu_pkg::REG_TANGENT_P2, -24'sd2000);
      send(20'd163840, 20'd122880);
      send(0, 0);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'd327680, 20'd245760);
      drain();
      // extreme coefficients, tiny focal: overflow and zero or negative divisor
      csr_write(lpu_pkg::REG_FOCAL_X, 20'd1);
      csr_write(lpu_pkg::REG_FOCAL_Y, 20'hFFFFF);
      csr_write(lpu_pkg::REG_CENTER_X, 20'hFFFFF);
      csr_write(lpu_pkg::REG_CENTER_Y, 20'd0);
      csr_write(lpu_pkg::REG_RADIAL_K1, 24'h800000);
      csr_write(lpu_pkg::REG_RADIAL_K2, 24'h7FFFFF);
      csr_write(lpu_pkg::REG_TANGENT_P1, 24'h7FFFFF);
      csr_write(lpu_pkg::REG_TANGENT_P2, 24'h800000);
      send(0, 0);
      send(20'hFFFFF, 20'hFFFFF);
      send(20'hFFFFE, 20'd12345);
      drain();
      // k1 = -1 with r2 = 1 gives a zero divisor
      csr_write(lpu_pkg::REG_FOCAL_X, 20'd256);
      csr_write(lpu_pkg::REG_FOCAL_Y, 20'd256);
      csr_write(lpu_pkg::REG_CENTER_X, 20'd0);
      csr_write(lpu_pkg::REG_CENTER_Y, 20'd0);
      csr_write(lpu_pkg::REG_RADIAL_K1, -24'sd1048576);
      csr_write(lpu_pkg::REG_RADIAL_K2, 24'sd0);
      csr_write(lpu_pkg::REG_TANGENT_P1, 24'sd0);
      csr_write(lpu_pkg::REG_TANGENT_P2, 24'sd0);
      send(20'd256, 20'd0);
      send(20'd0, 20'd256);
      send(20'd0, 20'd0);
      send(20'd512, 20'd512);
      drain();
      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         csr_write(lpu_pkg::REG_FOCAL_X, $urandom_range(0, 3) == 0
                   ? $urandom_range(1, 20'hFFFFF) : $urandom_range(20000, 400000));
         csr_write(lpu_pkg::REG_FOCAL_Y, $urandom_range(0, 3) == 0
                   ? $urandom_range(1, 20'hFFFFF) : $urandom_range(20000, 400000));
         csr_write(lpu_pkg::REG_CENTER_X, rand_pixel());
         csr_write(lpu_pkg::REG_CENTER_Y, rand_pixel());
         csr_write(lpu_pkg::REG_RADIAL_K1, rand_coef(300000));
         csr_write(lpu_pkg::REG_RADIAL_K2, rand_coef(100000));
         csr_write(lpu_pkg::REG_TANGENT_P1, rand_coef(5000));
         csr_write(lpu_pkg::REG_TANGENT_P2, rand_coef(5000));
         for (int i = 0; i < 100; i++) send(rand_pixel(), rand_pixel());
         // sender holds off until all results are back
         while (pixel_queue.size() != 0 || req_valid) tick();
         hold_sender = 1'b1;
         while (norm_queue.size() != 0) tick();
         hold_sender = 1'b0;
         for (int i = 0; i < 100; i++) send(rand_pixel(), rand_pixel());
         drain();
      end
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule
